>>> hdl/nirdec_pkg.sv
package nirdec_pkg;

   localparam int unsigned TICKS_W                = 15;
   localparam int unsigned US_W                   = 16;
   localparam int unsigned DATA_W                 = 16;
   localparam int unsigned STATUS_W               = 2;
   localparam int unsigned CSR_INDEX_W            = 3;
   localparam int unsigned CSR_DATA_W             = 16;
   localparam int unsigned PAIR_INDEX_W           = 6;
   localparam int unsigned TICKS_PER_10US_DEFAULT = 8;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BIT    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHORT      = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE_US    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_MARK_US  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SPACE_US = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_MARK_US     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_SPACE_US    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_SPACE_US   = 3'd6;

   localparam logic            RESET_ACTIVE_LEVEL    = 1'b0;
   localparam logic [US_W-1:0] RESET_TOLERANCE_US    = 16'd320;
   localparam logic [US_W-1:0] RESET_HEADER_MARK_US  = 16'd9000;
   localparam logic [US_W-1:0] RESET_HEADER_SPACE_US = 16'd4500;
   localparam logic [US_W-1:0] RESET_BIT_MARK_US     = 16'd560;
   localparam logic [US_W-1:0] RESET_ONE_SPACE_US    = 16'd1690;
   localparam logic [US_W-1:0] RESET_ZERO_SPACE_US   = 16'd560;

   localparam logic [PAIR_INDEX_W-1:0] PAIR_HEADER       = 6'd0;
   localparam logic [PAIR_INDEX_W-1:0] PAIR_LAST_ADDRESS = 6'd16;
   localparam logic [PAIR_INDEX_W-1:0] PAIR_DONE         = 6'd33;

   typedef struct packed {
      logic               first_level;
      logic [TICKS_W-1:0] first_ticks;
      logic               second_level;
      logic [TICKS_W-1:0] second_ticks;
      logic               frame_first;
      logic               frame_last;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   address;
      logic [DATA_W-1:0]   command;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic header;
      logic one;
      logic zero;
   } match_type;

endpackage

>>> hdl/nec_ir_pulse_decoder.sv
// NEC infrared pulse-pair decoder.
// The input channel (req_valid, req_ready, req_item) takes one pulse pair per
// item, marked with the first and last pair of its frame. The result channel
// (rsp_valid, rsp_ready, rsp_item) gives one item per decoded frame, or one
// error item for a bad header, a bad bit or a frame that ends early.
// The configuration port writes a timing register at every clock edge with
// csr_write_en high; write it only while no pairs are in flight.
// An accepted pair sits in the input register, where the three window
// matchers and the frame logic evaluate it; once the output register is
// free, the pair steps on and any result is registered there and valid.
// Throughput is one pair per cycle while results flow (single input stage).
// When the receiver stalls with a result waiting, one more pair may be held
// in the input register; req_ready then drops until the result is taken.
// Reset restores the default NEC timings, clears both registers and drops
// any partly decoded frame.
module nec_ir_pulse_decoder #(
   parameter int unsigned TICKS_PER_10US = nirdec_pkg::TICKS_PER_10US_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  nirdec_pkg::req_type                req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output nirdec_pkg::rsp_type                rsp_item,
   input  logic                               csr_write_en,
   input  logic [nirdec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nirdec_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nirdec_pkg::*;

   logic            active_level_ff;
   logic [US_W-1:0] tolerance_us_ff;
   logic [US_W-1:0] header_mark_us_ff;
   logic [US_W-1:0] header_space_us_ff;
   logic [US_W-1:0] bit_mark_us_ff;
   logic [US_W-1:0] one_space_us_ff;
   logic [US_W-1:0] zero_space_us_ff;

   logic    pair_valid_ff, pair_valid_in;
   req_type pair_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic      out_free;
   logic      step;
   logic      emit;
   rsp_type   frame_rsp;
   match_type match;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff    <= RESET_ACTIVE_LEVEL;
         tolerance_us_ff    <= RESET_TOLERANCE_US;
         header_mark_us_ff  <= RESET_HEADER_MARK_US;
         header_space_us_ff <= RESET_HEADER_SPACE_US;
         bit_mark_us_ff     <= RESET_BIT_MARK_US;
         one_space_us_ff    <= RESET_ONE_SPACE_US;
         zero_space_us_ff   <= RESET_ZERO_SPACE_US;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL:    active_level_ff    <= csr_wdata[0];
            CSR_TOLERANCE_US:    tolerance_us_ff    <= US_W'(csr_wdata);
            CSR_HEADER_MARK_US:  header_mark_us_ff  <= US_W'(csr_wdata);
            CSR_HEADER_SPACE_US: header_space_us_ff <= US_W'(csr_wdata);
            CSR_BIT_MARK_US:     bit_mark_us_ff     <= US_W'(csr_wdata);
            CSR_ONE_SPACE_US:    one_space_us_ff    <= US_W'(csr_wdata);
            CSR_ZERO_SPACE_US:   zero_space_us_ff   <= US_W'(csr_wdata);
            default:             ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = pair_valid_ff && out_free;
   assign req_ready = !pair_valid_ff || out_free;

   always_comb begin
      pair_valid_in = pair_valid_ff;
      if (req_ready) begin
         pair_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pair_ff <= req_item;
      end
      if (step && emit) begin
         rsp_ff <= frame_rsp;
      end
   end

   nirdec_match #(.TICKS_PER_10US(TICKS_PER_10US)) u_match_header (
      .active_level (active_level_ff),
      .tolerance_us (tolerance_us_ff),
      .mark_us      (header_mark_us_ff),
      .space_us     (header_space_us_ff),
      .item         (pair_ff),
      .hit          (match.header)
   );

   nirdec_match #(.TICKS_PER_10US(TICKS_PER_10US)) u_match_one (
      .active_level (active_level_ff),
      .tolerance_us (tolerance_us_ff),
      .mark_us      (bit_mark_us_ff),
      .space_us     (one_space_us_ff),
      .item         (pair_ff),
      .hit          (match.one)
   );

   nirdec_match #(.TICKS_PER_10US(TICKS_PER_10US)) u_match_zero (
      .active_level (active_level_ff),
      .tolerance_us (tolerance_us_ff),
      .mark_us      (bit_mark_us_ff),
      .space_us     (zero_space_us_ff),
      .item         (pair_ff),
      .hit          (match.zero)
   );

   nirdec_frame u_frame (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (pair_ff),
      .match (match),
      .emit  (emit),
      .rsp   (frame_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hdl/nirdec_match.sv
module nirdec_match #(
   parameter int unsigned TICKS_PER_10US = nirdec_pkg::TICKS_PER_10US_DEFAULT
) (
   input  logic                        active_level,
   input  logic [nirdec_pkg::US_W-1:0] tolerance_us,
   input  logic [nirdec_pkg::US_W-1:0] mark_us,
   input  logic [nirdec_pkg::US_W-1:0] space_us,
   input  nirdec_pkg::req_type         item,
   output logic                        hit
);
   import nirdec_pkg::*;

   // Windows are compared in the tick domain, scaled by the tick rate, so no
   // division by the tick rate is needed.
   localparam int unsigned KW = $clog2(TICKS_PER_10US + 1);
   localparam int unsigned XW = TICKS_W + 4;
   localparam int unsigned SW = US_W + 1;
   localparam int unsigned HW = SW + KW;
   localparam int unsigned CW = (HW > XW) ? HW : XW;
   localparam logic [KW-1:0] TICK_RATE = KW'(TICKS_PER_10US);

   function automatic logic near(input logic [TICKS_W-1:0] ticks,
                                 input logic [US_W-1:0] target,
                                 input logic [US_W-1:0] margin);
      logic [CW-1:0] scaled;
      logic [CW-1:0] upper;
      logic [CW-1:0] lower;
      logic [SW-1:0] sum;
      logic [SW-1:0] diff;
      scaled = CW'(ticks) * CW'(10);
      sum    = {1'b0, target} + {1'b0, margin};
      diff   = {1'b0, target} - {1'b0, margin} + SW'(1);
      upper  = CW'(sum) * CW'(TICK_RATE);
      lower  = CW'(diff) * CW'(TICK_RATE);
      return (scaled < upper) && ((target < margin) || (scaled >= lower));
   endfunction

   assign hit = (item.first_level == active_level)
             && (item.second_level != active_level)
             && near(item.first_ticks, mark_us, tolerance_us)
             && near(item.second_ticks, space_us, tolerance_us);

endmodule

>>> hdl/nirdec_frame.sv
module nirdec_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  nirdec_pkg::req_type   item,
   input  nirdec_pkg::match_type match,
   output logic                  emit,
   output nirdec_pkg::rsp_type   rsp
);
   import nirdec_pkg::*;

   logic                    active_ff,  active_in;
   logic [PAIR_INDEX_W-1:0] index_ff,   index_in;
   logic [DATA_W-1:0]       address_ff, address_in;
   logic [DATA_W-1:0]       command_ff, command_in;

   logic                    frame_on;
   logic [PAIR_INDEX_W-1:0] index_cur;
   logic [PAIR_INDEX_W-1:0] index_next;
   logic [DATA_W-1:0]       address_cur;
   logic [DATA_W-1:0]       command_cur;

   always_comb begin
      frame_on    = item.frame_first | active_ff;
      index_cur   = item.frame_first ? '0 : index_ff;
      address_cur = item.frame_first ? '0 : address_ff;
      command_cur = item.frame_first ? '0 : command_ff;
      index_next  = index_cur + PAIR_INDEX_W'(1);

      active_in  = active_ff;
      index_in   = index_ff;
      address_in = address_ff;
      command_in = command_ff;
      emit       = 1'b0;
      rsp        = '{address: '0, command: '0, status: STATUS_OK};

      if (frame_on) begin
         active_in  = 1'b1;
         index_in   = index_cur;
         address_in = address_cur;
         command_in = command_cur;
         if (index_cur == PAIR_HEADER) begin
            if (!match.header) begin
               emit       = 1'b1;
               rsp.status = STATUS_BAD_HEADER;
               active_in  = 1'b0;
            end else begin
               index_in = index_next;
            end
         end else if (!match.one && !match.zero) begin
            emit       = 1'b1;
            rsp.status = STATUS_BAD_BIT;
            active_in  = 1'b0;
         end else begin
            if (index_cur <= PAIR_LAST_ADDRESS) begin
               address_in = {match.one, address_cur[DATA_W-1:1]};
            end else begin
               command_in = {match.one, command_cur[DATA_W-1:1]};
            end
            index_in = index_next;
         end
         if (!emit) begin
            if (index_in == PAIR_DONE) begin
               emit        = 1'b1;
               rsp.address = address_in;
               rsp.command = command_in;
               rsp.status  = STATUS_OK;
               active_in   = 1'b0;
            end else if (item.frame_last) begin
               emit       = 1'b1;
               rsp.status = STATUS_SHORT;
               active_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         index_ff   <= '0;
         address_ff <= '0;
         command_ff <= '0;
      end else if (step) begin
         active_ff  <= active_in;
         index_ff   <= index_in;
         address_ff <= address_in;
         command_ff <= command_in;
      end
   end

endmodule
